// ===== hdl/key_autorepeat_tracker_top_macros.svh =====
// ----------------------------------------------------------------------------
// Key auto-repeat tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEY_AUTOREPEAT_TRACKER_TOP_MACROS_SVH
`define KEY_AUTOREPEAT_TRACKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KAT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KAT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/kat_pkg.sv =====
// ----------------------------------------------------------------------------
// Key auto-repeat tracker package
// Types, constants and codes shared by the tracker's modules.
// ----------------------------------------------------------------------------
package kat_pkg;

    localparam int NUM_KEYS = 256;
    localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [8:0]  KEY_COUNT_RESET       = 9'd256;
    localparam logic [15:0] REPEAT_INTERVAL_RESET = 16'd100;
    localparam logic [15:0] TALLY_MAX             = 16'hFFFF;

    localparam logic [1:0] CFG_KEY_COUNT       = 2'd0;
    localparam logic [1:0] CFG_REPEAT_INTERVAL = 2'd1;

    localparam logic MODE_PRESS   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [1:0] KIND_DOWN    = 2'd0;
    localparam logic [1:0] KIND_PRESSED = 2'd1;
    localparam logic [1:0] KIND_UP      = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [7:0]  key_code;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  event_code;
        logic [31:0] press_time;
        logic [31:0] held_for;
        logic [15:0] repeats;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [8:0]  key_count;
        logic [15:0] repeat_interval_ms;
    } cfg_regs_t;

    typedef struct packed {
        logic [31:0] stamp;
        logic [15:0] tally;
    } key_entry_t;

endpackage

// ===== hdl/kat_front.sv =====
// ----------------------------------------------------------------------------
// Key auto-repeat tracker front end
// Holds the configuration registers, accepts reports and drops those whose
// scan code is out of range before they reach the queue.
// ----------------------------------------------------------------------------
module kat_front
    import kat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       push_valid,
    input  logic       push_ready,
    output in_item_t   push_data,
    output cfg_regs_t  cfg
);

    localparam logic [8:0] NUM_KEYS_W = 9'(NUM_KEYS);

    logic [8:0]  key_count_reg;
    logic [15:0] interval_reg;
    logic        in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= KEY_COUNT_RESET;
            interval_reg  <= REPEAT_INTERVAL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KEY_COUNT:       key_count_reg <= cfg_data[8:0];
                CFG_REPEAT_INTERVAL: interval_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        in_range = ({1'b0, in_data.key_code} < key_count_reg) &&
                   ({1'b0, in_data.key_code} < NUM_KEYS_W);
    end

    assign cfg_ready              = 1'b1;
    assign in_ready               = push_ready;
    assign push_valid             = in_valid && in_range;
    assign push_data              = in_data;
    assign cfg.key_count          = key_count_reg;
    assign cfg.repeat_interval_ms = interval_reg;

endmodule

// ===== hdl/kat_queue.sv =====
// ----------------------------------------------------------------------------
// Key auto-repeat tracker queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module kat_queue
    import kat_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  in_item_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output in_item_t pop_data
);

    localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

    in_item_t                 entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic                     do_push;
    logic                     do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/kat_back.sv =====
// ----------------------------------------------------------------------------
// Key auto-repeat tracker back end
// Keeps the per-key table, decides the events of each report and delivers
// them through an output register.
// ----------------------------------------------------------------------------
`include "key_autorepeat_tracker_top_macros.svh"

module kat_back
    import kat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_regs_t cfg,
    input  logic      q_valid,
    output logic      q_ready,
    input  in_item_t  q_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_READ = 4'b0010,
        B_CALC = 4'b0100,
        B_EMIT = 4'b1000
    } back_state_t;

    back_state_t           state_reg;
    back_state_t           state_next;
    key_entry_t            table_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0]   key_held_reg;
    in_item_t              item_reg;
    logic                  held_reg;
    key_entry_t            entry_rd_reg;
    logic [31:0]           elapsed_reg;
    logic [32:0]           product_reg;
    out_item_t             res_reg [2];
    logic                  res_two_reg;
    logic                  res_idx_reg;
    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    logic [KEY_IDX_W-1:0]  key_idx;
    logic [KEY_IDX_W-1:0]  q_key_idx;
    logic                  do_pop;
    logic                  out_free;
    logic                  out_load;
    logic [16:0]           tally_inc;
    logic                  repeat_due;
    logic [1:0]            n_results;
    out_item_t             res0;
    out_item_t             res1;
    logic                  mem_we;
    key_entry_t            mem_wdata;
    logic                  held_set;
    logic                  held_clr;

    assign key_idx   = item_reg.key_code[KEY_IDX_W-1:0];
    assign q_key_idx = q_data.key_code[KEY_IDX_W-1:0];
    assign q_ready   = (state_reg == B_IDLE);
    assign do_pop    = q_valid && q_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == B_EMIT) && out_free;
    assign tally_inc = {1'b0, entry_rd_reg.tally} + 17'd1;
    assign repeat_due = {1'b0, elapsed_reg} > product_reg;

    always_comb
    begin
        n_results = 2'd0;
        res0      = '0;
        res1      = '0;
        mem_we    = 1'b0;
        mem_wdata = entry_rd_reg;
        held_set  = 1'b0;
        held_clr  = 1'b0;
        res0.event_code = item_reg.key_code;
        res1.event_code = item_reg.key_code;
        res0.press_time = entry_rd_reg.stamp;
        res1.press_time = entry_rd_reg.stamp;
        res0.held_for   = elapsed_reg;
        res1.held_for   = elapsed_reg;
        if (state_reg == B_CALC)
        begin
            if (item_reg.mode == MODE_PRESS)
            begin
                if (!held_reg)
                begin
                    held_set        = 1'b1;
                    mem_we          = 1'b1;
                    mem_wdata.stamp = item_reg.now_ms;
                    mem_wdata.tally = '0;
                    res0.event_kind = KIND_DOWN;
                    res0.press_time = item_reg.now_ms;
                    res0.held_for   = '0;
                    res0.repeats    = '0;
                    res0.last       = 1'b1;
                    n_results       = 2'd1;
                end
                else if ((entry_rd_reg.tally != TALLY_MAX) && repeat_due)
                begin
                    mem_we          = 1'b1;
                    mem_wdata.tally = tally_inc[15:0];
                    res0.event_kind = KIND_PRESSED;
                    res0.repeats    = tally_inc[15:0];
                    res0.last       = 1'b1;
                    n_results       = 2'd1;
                end
            end
            else if (held_reg)
            begin
                held_clr = 1'b1;
                if (entry_rd_reg.tally == '0)
                begin
                    res0.event_kind = KIND_PRESSED;
                    res0.repeats    = '0;
                    res0.last       = 1'b0;
                    res1.event_kind = KIND_UP;
                    res1.repeats    = '0;
                    res1.last       = 1'b1;
                    n_results       = 2'd2;
                end
                else
                begin
                    res0.event_kind = KIND_UP;
                    res0.repeats    = entry_rd_reg.tally;
                    res0.last       = 1'b1;
                    n_results       = 2'd1;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_CALC;
            end
            B_CALC:
            begin
                state_next = (n_results == 2'd0) ? B_IDLE : B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free && (res_idx_reg == res_two_reg))
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            key_held_reg  <= '0;
            out_valid_reg <= 1'b0;
            res_idx_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (held_set)
            begin
                key_held_reg[key_idx] <= 1'b1;
            end
            else if (held_clr)
            begin
                key_held_reg[key_idx] <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == B_CALC)
            begin
                res_idx_reg <= 1'b0;
            end
            else if (out_load)
            begin
                res_idx_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            item_reg     <= q_data;
            held_reg     <= key_held_reg[q_key_idx];
            entry_rd_reg <= table_mem[q_key_idx];
        end
        if (mem_we)
        begin
            table_mem[key_idx] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_READ)
        begin
            elapsed_reg <= item_reg.now_ms - entry_rd_reg.stamp;
            product_reg <= 33'(tally_inc) * 33'(cfg.repeat_interval_ms);
        end
        if (state_reg == B_CALC)
        begin
            res_reg[0]  <= res0;
            res_reg[1]  <= res1;
            res_two_reg <= (n_results == 2'd2);
        end
        if (out_load)
        begin
            out_data_reg <= res_reg[res_idx_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `KAT_ASSERT_IMP(a_down_fresh, out_valid_reg && (out_data_reg.event_kind == KIND_DOWN), (out_data_reg.held_for == '0) && (out_data_reg.repeats == '0) && out_data_reg.last, "key down event carries stale hold data")
    `KAT_ASSERT_IMP(a_pressed_last, out_valid_reg && (out_data_reg.event_kind == KIND_PRESSED), out_data_reg.last == (out_data_reg.repeats != '0), "pressed event last flag disagrees with repeat count")
    `KAT_ASSERT_NXT(a_release_clears, (state_reg == B_CALC) && (item_reg.mode == MODE_RELEASE), !key_held_reg[$past(key_idx)], "released key is still marked as held")

endmodule

// ===== hdl/key_autorepeat_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Key auto-repeat tracker
// Tracks the held state of each key and reports key down, auto-repeat and
// key up events for press and release reports.
// ----------------------------------------------------------------------------
// Each report passes the back end's read and calculate states, which do the table
// read, multiply, compare and write-back, then the emit state for any results; the
// back end takes the next report from the queue only once it is idle again.
// Two reports may wait in the queue while the back end works or is stalled.
// Reset: all held flags clear at once, key_count returns to 256 and the
// repeat interval to 100 ms; no clearing pass is needed.
module key_autorepeat_tracker_top
    import kat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    cfg_regs_t cfg;
    logic      push_valid;
    logic      push_ready;
    in_item_t  push_data;
    logic      pop_valid;
    logic      pop_ready;
    in_item_t  pop_data;

    kat_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .cfg        (cfg)
    );

    kat_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    kat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_data    (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== tb/key_autorepeat_tracker_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key auto-repeat tracker testbench
// Drives press and release reports and register writes into the tracker,
// predicts the key down, auto-repeat and key up events with a shadow copy
// of the key table, and checks each event field by field. Directed cases
// cover the field and register extremes, time wrap and a zero interval;
// random traffic then runs under several settings with random gaps and
// back-pressure.
// ----------------------------------------------------------------------------
module key_autorepeat_tracker_top_tb;

    import kat_pkg::*;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          PRINT_CAP     = 100;
    localparam logic [1:0]  CFG_UNUSED    = 2'd3;

    typedef enum logic [1:0] {OP_REPORT, OP_WRITE, OP_SETTLE} op_kind_t;
    typedef enum logic [1:0] {DRV_FETCH, DRV_GAP, DRV_SEND, DRV_DRAIN} drv_state_t;

    typedef struct {
        op_kind_t    kind;
        in_item_t    report;
        logic [1:0]  reg_index;
        logic [15:0] reg_data;
        int          gap;
        bit          rush;
    } stim_op_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;

    stim_op_t    pending_ops[$];
    out_item_t   due_events[$];
    stim_op_t    cur_op;
    drv_state_t  drv_state    = DRV_FETCH;
    int          gap_left     = 0;
    int          settle_left  = 0;
    int          stall_left   = 0;
    int          tx_calm_left = 0;
    int          rx_calm_left = 0;
    bit          fill_rush    = 1'b0;
    logic        rx_rush      = 1'b0;
    int          mismatches   = 0;
    int          cycle_count  = 0;

    logic        held_keys [NUM_KEYS];
    logic [31:0] press_stamp [NUM_KEYS];
    logic [15:0] repeat_cnt[NUM_KEYS];
    logic [8:0]  key_count_q  = KEY_COUNT_RESET;
    logic [15:0] interval_q   = REPEAT_INTERVAL_RESET;

    key_autorepeat_tracker_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic flag_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic push_event(logic [1:0] kind, logic [7:0] code, logic [31:0] down,
                              logic [31:0] span, logic [15:0] reps, logic fin);
        out_item_t ev;
        ev.event_kind = kind;
        ev.event_code = code;
        ev.press_time = down;
        ev.held_for   = span;
        ev.repeats    = reps;
        ev.last       = fin;
        due_events.push_back(ev);
    endtask

    task automatic track_report(in_item_t r);
        logic [31:0] span;
        int          c;
        c = int'(r.key_code);
        if ({1'b0, r.key_code} >= key_count_q || c >= NUM_KEYS)
        begin
            return;
        end
        span = r.now_ms - press_stamp[c];
        if (r.mode == MODE_PRESS)
        begin
            if (!held_keys[c])
            begin
                held_keys[c]   = 1'b1;
                repeat_cnt[c]  = '0;
                press_stamp[c] = r.now_ms;
                push_event(KIND_DOWN, r.key_code, r.now_ms, 32'd0, 16'd0, 1'b1);
            end
            else if (repeat_cnt[c] != TALLY_MAX &&
                     {32'd0, span} > (64'(repeat_cnt[c]) + 64'd1) * 64'(interval_q))
            begin
                repeat_cnt[c] = repeat_cnt[c] + 16'd1;
                push_event(KIND_PRESSED, r.key_code, press_stamp[c], span, repeat_cnt[c], 1'b1);
            end
        end
        else if (held_keys[c])
        begin
            if (repeat_cnt[c] == '0)
            begin
                push_event(KIND_PRESSED, r.key_code, press_stamp[c], span, 16'd0, 1'b0);
            end
            push_event(KIND_UP, r.key_code, press_stamp[c], span, repeat_cnt[c], 1'b1);
            held_keys[c] = 1'b0;
        end
    endtask

    task automatic write_shadow(logic [1:0] idx, logic [15:0] data);
        if (idx == CFG_KEY_COUNT)
        begin
            key_count_q = data[8:0];
        end
        else if (idx == CFG_REPEAT_INTERVAL)
        begin
            interval_q = data;
        end
    endtask

    task automatic check_event(out_item_t got);
        out_item_t want;
        if (due_events.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected event kind %0d code %0h",
                                    got.event_kind, got.event_code));
            return;
        end
        want = due_events.pop_front();
        if (got.event_kind !== want.event_kind)
            flag_mismatch($sformatf("event_kind got %0d expected %0d (code %0h)",
                                    got.event_kind, want.event_kind, want.event_code));
        if (got.event_code !== want.event_code)
            flag_mismatch($sformatf("event_code got %0h expected %0h",
                                    got.event_code, want.event_code));
        if (got.press_time !== want.press_time)
            flag_mismatch($sformatf("press_time got %0h expected %0h (code %0h)",
                                    got.press_time, want.press_time, want.event_code));
        if (got.held_for !== want.held_for)
            flag_mismatch($sformatf("held_for got %0h expected %0h (code %0h)",
                                    got.held_for, want.held_for, want.event_code));
        if (got.repeats !== want.repeats)
            flag_mismatch($sformatf("repeats got %0d expected %0d (code %0h)",
                                    got.repeats, want.repeats, want.event_code));
        if (got.last !== want.last)
            flag_mismatch($sformatf("last got %0b expected %0b (code %0h)",
                                    got.last, want.last, want.event_code));
    endtask

    function automatic int draw_gap();
        if (fill_rush)
            return 0;
        if (tx_calm_left > 0)
        begin
            tx_calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            tx_calm_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic int draw_stall();
        if (rx_rush)
            return 0;
        if (rx_calm_left > 0)
        begin
            rx_calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            rx_calm_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic void add_report(logic mode, logic [7:0] code, logic [31:0] stamp);
        stim_op_t op;
        op.kind      = OP_REPORT;
        op.report    = '{mode: mode, key_code: code, now_ms: stamp};
        op.reg_index = '0;
        op.reg_data  = '0;
        op.gap       = draw_gap();
        op.rush      = fill_rush;
        pending_ops.push_back(op);
    endfunction

    function automatic void add_write(logic [1:0] idx, logic [15:0] data);
        stim_op_t op;
        op.kind      = OP_WRITE;
        op.report    = '0;
        op.reg_index = idx;
        op.reg_data  = data;
        op.gap       = draw_gap();
        op.rush      = fill_rush;
        pending_ops.push_back(op);
    endfunction

    function automatic void add_settle();
        stim_op_t op;
        op.kind      = OP_SETTLE;
        op.report    = '0;
        op.reg_index = '0;
        op.reg_data  = '0;
        op.gap       = 0;
        op.rush      = fill_rush;
        pending_ops.push_back(op);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic next_in_valid;
        logic next_cfg_valid;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            cfg_valid   <= 1'b0;
            in_data     <= '0;
            cfg_index   <= '0;
            cfg_data    <= '0;
            rx_rush     <= 1'b0;
            drv_state   = DRV_FETCH;
            gap_left    = 0;
            settle_left = 0;
            key_count_q = KEY_COUNT_RESET;
            interval_q  = REPEAT_INTERVAL_RESET;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                held_keys[k] = 1'b0;
            end
        end
        else
        begin
            next_in_valid  = in_valid;
            next_cfg_valid = cfg_valid;
            if (in_valid && in_ready)
            begin
                track_report(in_data);
                next_in_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                write_shadow(cfg_index, cfg_data);
                next_cfg_valid = 1'b0;
            end
            if (drv_state == DRV_SEND && !next_in_valid && !next_cfg_valid)
            begin
                drv_state = DRV_FETCH;
            end
            if (drv_state == DRV_FETCH && pending_ops.size() != 0)
            begin
                cur_op      = pending_ops.pop_front();
                gap_left    = cur_op.gap;
                settle_left = SETTLE_CYCLES;
                rx_rush     <= cur_op.rush;
                drv_state   = (cur_op.kind == OP_SETTLE) ? DRV_DRAIN : DRV_GAP;
            end
            if (drv_state == DRV_DRAIN)
            begin
                if (due_events.size() != 0)
                    settle_left = SETTLE_CYCLES;
                else if (settle_left > 0)
                    settle_left--;
                else
                    drv_state = DRV_FETCH;
            end
            if (drv_state == DRV_GAP)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (cur_op.kind == OP_REPORT)
                begin
                    next_in_valid = 1'b1;
                    in_data       <= cur_op.report;
                    drv_state     = DRV_SEND;
                end
                else
                begin
                    next_cfg_valid = 1'b1;
                    cfg_index      <= cur_op.reg_index;
                    cfg_data       <= cur_op.reg_data;
                    drv_state      = DRV_SEND;
                end
            end
            in_valid  <= next_in_valid;
            cfg_valid <= next_cfg_valid;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic next_ready;
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            stall_left   = 0;
            rx_calm_left = 0;
        end
        else
        begin
            next_ready = out_ready;
            if (out_valid && out_ready)
            begin
                check_event(out_data);
                next_ready = 1'b0;
                stall_left = draw_stall();
            end
            if (!next_ready)
            begin
                if (stall_left > 0)
                    stall_left--;
                else
                    next_ready = 1'b1;
            end
            out_ready <= next_ready;
        end
    end

    initial
    begin
        logic [15:0] kc_data;
        logic [15:0] iv_data;
        logic [7:0]  pool[4];
        logic [31:0] tick;
        int          eff;
        int          stride;

        // Directed: default settings, repeat threshold, wrap and release paths.
        add_report(MODE_PRESS,   8'h00, 32'd0);
        add_report(MODE_PRESS,   8'h00, 32'd100);
        add_report(MODE_PRESS,   8'h00, 32'd101);
        add_report(MODE_PRESS,   8'h00, 32'd150);
        add_report(MODE_RELEASE, 8'h00, 32'd250);
        add_report(MODE_RELEASE, 8'h00, 32'd260);
        add_report(MODE_PRESS,   8'hFF, 32'hFFFF_FFF0);
        add_report(MODE_RELEASE, 8'hFF, 32'h0000_0010);
        add_report(MODE_PRESS,   8'h80, 32'hFFFF_FFFF);
        add_report(MODE_PRESS,   8'h80, 32'h0000_0070);
        add_report(MODE_RELEASE, 8'h80, 32'h7FFF_FFFF);
        add_report(MODE_PRESS,   8'h55, 32'd0);
        add_report(MODE_PRESS,   8'hAA, 32'd0);
        add_report(MODE_RELEASE, 8'h55, 32'd0);
        add_report(MODE_RELEASE, 8'hAA, 32'hFFFF_FFFF);

        add_settle();
        add_write(CFG_KEY_COUNT, 16'd0);
        add_report(MODE_PRESS, 8'h00, 32'd5);
        add_report(MODE_PRESS, 8'hFF, 32'd5);
        add_settle();
        add_write(CFG_KEY_COUNT, 16'd16);
        add_report(MODE_PRESS,   8'h10, 32'd7);
        add_report(MODE_PRESS,   8'h0F, 32'd7);
        add_report(MODE_RELEASE, 8'h0F, 32'd9);
        add_settle();
        add_write(CFG_KEY_COUNT, 16'hFFFF);
        add_write(CFG_UNUSED, 16'h0001);
        add_report(MODE_PRESS, 8'hC8, 32'd1000);

        add_settle();
        add_write(CFG_REPEAT_INTERVAL, 16'd0);
        add_report(MODE_PRESS,   8'h07, 32'd5);
        add_report(MODE_PRESS,   8'h07, 32'd5);
        add_report(MODE_PRESS,   8'h07, 32'd6);
        add_report(MODE_PRESS,   8'h07, 32'd6);
        add_report(MODE_RELEASE, 8'h07, 32'd8);
        add_settle();
        add_write(CFG_REPEAT_INTERVAL, 16'hFFFF);
        add_report(MODE_PRESS,   8'h09, 32'd0);
        add_report(MODE_PRESS,   8'h09, 32'd65535);
        add_report(MODE_PRESS,   8'h09, 32'd65536);
        add_report(MODE_RELEASE, 8'h09, 32'd70000);

        // A zero interval repeats on every press whose elapsed time is nonzero.
        add_settle();
        add_write(CFG_KEY_COUNT, 16'd256);
        add_write(CFG_REPEAT_INTERVAL, 16'd0);
        fill_rush = 1'b1;
        add_report(MODE_PRESS, 8'h03, 32'd0);
        for (int n = 0; n < 6; n++)
        begin
            add_report(MODE_PRESS, 8'h03, $urandom() | 32'd1);
        end
        add_report(MODE_PRESS,   8'h03, 32'hFFFF_FFFF);
        add_report(MODE_RELEASE, 8'h03, 32'h8000_0000);
        add_settle();
        fill_rush = 1'b0;

        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0: begin kc_data = 16'd256; iv_data = 16'd100; end
                1: begin
                       kc_data = 16'($urandom_range(1, 255));
                       iv_data = 16'($urandom_range(1, 300));
                   end
                2: begin
                       kc_data = 16'($urandom_range(256, 65535));
                       iv_data = 16'($urandom());
                   end
                3: begin kc_data = 16'd1; iv_data = 16'hFFFF; end
                4: begin kc_data = 16'd256; iv_data = 16'd0; end
                default: begin kc_data = 16'hFFFF; iv_data = 16'd1; end
            endcase
            add_settle();
            add_write(CFG_KEY_COUNT, kc_data);
            add_write(CFG_REPEAT_INTERVAL, iv_data);
            eff = (kc_data[8:0] > 9'd256) ? 256 : int'(kc_data[8:0]);
            for (int k = 0; k < 4; k++)
            begin
                pool[k] = (eff > 0) ? 8'($urandom_range(0, eff - 1)) : 8'($urandom_range(0, 255));
            end
            tick = (s % 2 == 1) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 2000)) : $urandom();
            stride = (iv_data == 16'd0) ? 2 : int'(iv_data) + int'(iv_data) / 2;
            for (int n = 0; n < 75; n++)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    tick = tick + 32'($urandom_range(0, stride));
                    add_report(($urandom_range(0, 99) < 70) ? MODE_PRESS : MODE_RELEASE,
                               pool[$urandom_range(0, 3)], tick);
                end
                else
                begin
                    add_report(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom());
                end
            end
        end
        add_settle();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while ((pending_ops.size() != 0 || drv_state != DRV_FETCH) && cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        if (due_events.size() != 0)
        begin
            flag_mismatch($sformatf("%0d expected events never arrived", due_events.size()));
        end
        if (cycle_count < CYCLE_LIMIT && mismatches == 0)
        begin
            $display("** key_autorepeat_tracker_top: PASSED **");
        end
        else
        begin
            $display("** key_autorepeat_tracker_top: FAILED **");
        end
        $finish;
    end

endmodule
